FILE: hw/rtl/lowest_free_room_scheduler_macros.svh
// Assertion macros shared by the lowest-free-room scheduler RTL.
`ifndef LOWEST_FREE_ROOM_SCHEDULER_MACROS_SVH
`define LOWEST_FREE_ROOM_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LFRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LFRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lfrs_pkg.sv
// Shared constants and types of the lowest-free-room scheduler.
package lfrs_pkg;

    localparam int TIME_W          = 40;
    localparam int ROOM_OUT_W      = 6;
    localparam int COUNT_W         = 20;
    localparam int CFG_W           = 7;
    localparam int DEF_MAX_ROOMS   = 64;
    localparam int DEF_TIME_BITS   = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]   CFG_RESET = 7'd64;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic start;
    } scan_ctl_t;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic done;
        logic found;
    } scan_sts_t;

endpackage

FILE: hw/rtl/lfrs_ram.sv
// Generic simple dual-port RAM with a registered read port.
module lfrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/lfrs_room_store.sv
// Per-room busy-until and booking-count storage with reset-valid bits.
module lfrs_room_store #(
    parameter int MAX_ROOMS = 64,
    parameter int TIME_BITS = 40,
    parameter int RW        = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [RW-1:0]               rd_addr,
    output logic [TIME_BITS-1:0]        rd_busy,
    output logic [lfrs_pkg::COUNT_W-1:0] rd_count,
    input  logic                        wr_en,
    input  logic [RW-1:0]               wr_addr,
    input  logic [TIME_BITS-1:0]        wr_busy,
    input  logic [lfrs_pkg::COUNT_W-1:0] wr_count
);
    import lfrs_pkg::*;

    logic [MAX_ROOMS-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [TIME_BITS-1:0] busy_q;
    logic [COUNT_W-1:0]   count_q;

    lfrs_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_ROOMS), .AW(RW)) u_busy_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_busy),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (busy_q)
    );

    lfrs_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ROOMS), .AW(RW)) u_count_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_count),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (count_q)
    );

    // A room never written since reset reads as free with no bookings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_busy  = rd_valid_reg ? busy_q  : '0;
    assign rd_count = rd_valid_reg ? count_q : '0;

endmodule

FILE: hw/rtl/lfrs_scan.sv
// Room scan unit: walks the rooms one per cycle and tracks both candidates.
module lfrs_scan #(
    parameter int MAX_ROOMS = 64,
    parameter int TIME_BITS = 40,
    parameter int RW        = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lfrs_pkg::scan_ctl_t          ctl,
    output lfrs_pkg::scan_sts_t          sts,
    input  logic [RW-1:0]                last_idx,
    input  logic [TIME_BITS-1:0]         start_time,
    output logic                         rd_en,
    output logic [RW-1:0]                rd_addr,
    input  logic [TIME_BITS-1:0]         rd_busy,
    input  logic [lfrs_pkg::COUNT_W-1:0] rd_count,
    output logic [RW-1:0]                found_room,
    output logic [lfrs_pkg::COUNT_W-1:0] found_count,
    output logic [RW-1:0]                early_room,
    output logic [TIME_BITS-1:0]         early_time,
    output logic [lfrs_pkg::COUNT_W-1:0] early_count
);
    `include "lowest_free_room_scheduler_macros.svh"
    import lfrs_pkg::*;

    logic                 issue_reg;
    logic [RW-1:0]        iss_idx_reg;
    logic                 d_valid_reg;
    logic [RW-1:0]        d_idx_reg;
    logic                 found_reg;
    logic [RW-1:0]        found_room_reg;
    logic [COUNT_W-1:0]   found_count_reg;
    logic [RW-1:0]        early_room_reg;
    logic [TIME_BITS-1:0] early_time_reg;
    logic [COUNT_W-1:0]   early_count_reg;

    // Address issue side: one read per cycle from room zero up to the last room.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= 1'b0;
            iss_idx_reg <= '0;
            d_valid_reg <= 1'b0;
            d_idx_reg   <= '0;
        end
        else
        begin
            d_valid_reg <= issue_reg;
            d_idx_reg   <= iss_idx_reg;
            if (ctl.start)
            begin
                issue_reg   <= 1'b1;
                iss_idx_reg <= '0;
            end
            else if (issue_reg)
            begin
                if (iss_idx_reg == last_idx)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    iss_idx_reg <= iss_idx_reg + 1'b1;
                end
            end
        end
    end

    // Data side: first free room wins, earliest release kept with strict compare.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (d_valid_reg && !found_reg && (rd_busy <= start_time))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_valid_reg)
        begin
            if (!found_reg && (rd_busy <= start_time))
            begin
                found_room_reg  <= d_idx_reg;
                found_count_reg <= rd_count;
            end
            if ((d_idx_reg == '0) || (rd_busy < early_time_reg))
            begin
                early_room_reg  <= d_idx_reg;
                early_time_reg  <= rd_busy;
                early_count_reg <= rd_count;
            end
        end
    end

    assign rd_en       = issue_reg;
    assign rd_addr     = iss_idx_reg;
    assign sts.done    = d_valid_reg && (d_idx_reg == last_idx);
    assign sts.found   = found_reg;
    assign found_room  = found_room_reg;
    assign found_count = found_count_reg;
    assign early_room  = early_room_reg;
    assign early_time  = early_time_reg;
    assign early_count = early_count_reg;

    `LFRS_ASSERT_IMP(a_scan_idx_range, d_valid_reg, d_idx_reg <= last_idx,
        "scan data index beyond the last active room")
    `LFRS_ASSERT_NXT(a_scan_restart, ctl.start, issue_reg && (iss_idx_reg == '0) && !found_reg,
        "scan did not restart from room zero")
    `LFRS_ASSERT_IMP(a_scan_done_idle, sts.done, !issue_reg,
        "scan reported done while reads were still issuing")

endmodule

FILE: hw/rtl/lowest_free_room_scheduler.sv
// Top level of the lowest-free-room scheduler: sequencer, arithmetic and ports.
//
// Booking scheduler for up to MAX_ROOMS rooms. Each input transfer carries a
// start and an end time (half open); the request goes to the lowest-numbered
// active room whose busy-until time is not after the start, or, when every
// active room is busy, to the room that frees earliest (lowest number on a
// tie), delayed to that release time with its duration kept. Each output
// transfer gives the room, the actual start and end times (end saturating at
// the largest time value), a delayed flag and the running busiest room with
// its booking count (counts saturate at 2^20-1). Start times are expected in
// increasing order; nothing checks it. The busy-until times and booking
// counts live in two synchronous RAMs, read one room per cycle by a scan
// unit. A request passes through the states idle (the transfer is taken),
// scan over the N active rooms (rooms_in_use, clamped to 1..MAX_ROOMS),
// including the registered RAM read, calc for the time arithmetic, and
// done, which writes the chosen room back and loads the output register.
// The write-back waits while a previous result is still unclaimed on the
// output; a new request is taken only when the previous one has been
// written back, so RAM reads never race a pending update. Reset leaves
// every room free with no bookings at once, without a clearing pass.
// The rooms_in_use register is written through cfg_write_en/cfg_write_data
// and must only change while the block is idle; rooms above the new count
// keep their state and still count toward the busiest room.
module lowest_free_room_scheduler #(
    parameter int MAX_ROOMS = lfrs_pkg::DEF_MAX_ROOMS,
    parameter int TIME_BITS = lfrs_pkg::DEF_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [lfrs_pkg::CFG_W-1:0]      cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lfrs_pkg::TIME_W-1:0]     start_time,
    input  logic [lfrs_pkg::TIME_W-1:0]     end_time,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lfrs_pkg::ROOM_OUT_W-1:0] room,
    output logic [lfrs_pkg::TIME_W-1:0]     actual_start,
    output logic [lfrs_pkg::TIME_W-1:0]     actual_end,
    output logic                            was_delayed,
    output logic [lfrs_pkg::ROOM_OUT_W-1:0] busiest_room,
    output logic [lfrs_pkg::COUNT_W-1:0]    busiest_count
);
    `include "lowest_free_room_scheduler_macros.svh"
    import lfrs_pkg::*;

    localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam logic [8:0] MAX_ROOMS_9 = 9'(MAX_ROOMS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     rooms_in_use_reg;
    logic [RW-1:0]        last_idx_reg;
    logic [RW-1:0]        last_idx_next;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] dur_reg;
    logic [TIME_BITS-1:0] start_in;
    logic [TIME_BITS-1:0] end_in;

    logic [RW-1:0]        sel_room_reg;
    logic [TIME_BITS-1:0] act_start_reg;
    logic [TIME_BITS-1:0] act_end_reg;
    logic [COUNT_W-1:0]   new_count_reg;
    logic                 delayed_reg;

    logic [RW-1:0]        best_room_reg;
    logic [COUNT_W-1:0]   best_count_reg;

    logic                 out_valid_reg;
    logic [RW-1:0]        out_room_reg;
    logic [TIME_BITS-1:0] out_start_reg;
    logic [TIME_BITS-1:0] out_end_reg;
    logic                 out_delayed_reg;
    logic [RW-1:0]        out_best_room_reg;
    logic [COUNT_W-1:0]   out_best_count_reg;

    logic                 in_xfer;
    logic                 slot_free;
    logic                 commit;
    logic [8:0]           riu_9;
    logic [8:0]           last_9;

    scan_ctl_t            scan_ctl;
    scan_sts_t            scan_sts;
    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic [TIME_BITS-1:0] rd_busy;
    logic [COUNT_W-1:0]   rd_count;
    logic [RW-1:0]        found_room;
    logic [COUNT_W-1:0]   found_count;
    logic [RW-1:0]        early_room;
    logic [TIME_BITS-1:0] early_time;
    logic [COUNT_W-1:0]   early_count;

    logic [RW-1:0]        calc_room;
    logic [TIME_BITS-1:0] calc_start;
    logic [COUNT_W-1:0]   calc_count;
    logic [TIME_BITS:0]   calc_sum;
    logic                 take_best;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign commit    = (state_reg == S_DONE) && slot_free;

    // Input times are taken modulo the internal time width.
    assign start_in = TIME_BITS'(start_time);
    assign end_in   = TIME_BITS'(end_time);

    // A room count of zero means one room; counts above MAX_ROOMS are clamped.
    always_comb
    begin
        riu_9 = 9'(rooms_in_use_reg);
        if (riu_9 == 9'd0)
        begin
            last_9 = 9'd0;
        end
        else if (riu_9 > MAX_ROOMS_9)
        begin
            last_9 = MAX_ROOMS_9 - 9'd1;
        end
        else
        begin
            last_9 = riu_9 - 9'd1;
        end
        last_idx_next = RW'(last_9);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rooms_in_use_reg <= CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            rooms_in_use_reg <= cfg_write_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_sts.done)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the request; a non-positive duration is taken as zero.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            start_reg    <= start_in;
            dur_reg      <= (end_in > start_in) ? (end_in - start_in) : '0;
            last_idx_reg <= last_idx_next;
        end
    end

    assign scan_ctl.start = in_xfer;

    lfrs_scan #(.MAX_ROOMS(MAX_ROOMS), .TIME_BITS(TIME_BITS), .RW(RW)) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .sts         (scan_sts),
        .last_idx    (last_idx_reg),
        .start_time  (start_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_busy     (rd_busy),
        .rd_count    (rd_count),
        .found_room  (found_room),
        .found_count (found_count),
        .early_room  (early_room),
        .early_time  (early_time),
        .early_count (early_count)
    );

    lfrs_room_store #(.MAX_ROOMS(MAX_ROOMS), .TIME_BITS(TIME_BITS), .RW(RW)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_busy  (rd_busy),
        .rd_count (rd_count),
        .wr_en    (commit),
        .wr_addr  (sel_room_reg),
        .wr_busy  (act_end_reg),
        .wr_count (new_count_reg)
    );

    // Pick the free room when there is one, otherwise the earliest release.
    always_comb
    begin
        calc_room  = scan_sts.found ? found_room  : early_room;
        calc_start = scan_sts.found ? start_reg   : early_time;
        calc_count = scan_sts.found ? found_count : early_count;
        calc_sum   = {1'b0, calc_start} + {1'b0, dur_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            sel_room_reg  <= calc_room;
            act_start_reg <= calc_start;
            act_end_reg   <= calc_sum[TIME_BITS] ? '1 : calc_sum[TIME_BITS-1:0];
            new_count_reg <= (calc_count == COUNT_MAX) ? calc_count : calc_count + 1'b1;
            delayed_reg   <= !scan_sts.found;
        end
    end

    assign take_best = (new_count_reg > best_count_reg) ||
                       ((new_count_reg == best_count_reg) && (sel_room_reg < best_room_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_room_reg  <= '0;
            best_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (commit && take_best)
            begin
                best_room_reg  <= sel_room_reg;
                best_count_reg <= new_count_reg;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_room_reg       <= sel_room_reg;
            out_start_reg      <= act_start_reg;
            out_end_reg        <= act_end_reg;
            out_delayed_reg    <= delayed_reg;
            out_best_room_reg  <= take_best ? sel_room_reg  : best_room_reg;
            out_best_count_reg <= take_best ? new_count_reg : best_count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign room          = ROOM_OUT_W'(out_room_reg);
    assign actual_start  = TIME_W'(out_start_reg);
    assign actual_end    = TIME_W'(out_end_reg);
    assign was_delayed   = out_delayed_reg;
    assign busiest_room  = ROOM_OUT_W'(out_best_room_reg);
    assign busiest_count = out_best_count_reg;

    `LFRS_ASSERT_NXT(a_accept_starts_scan, in_xfer, state_reg == S_SCAN,
        "accepted request did not start a scan")
    `LFRS_ASSERT_IMP(a_room_in_range, state_reg == S_CALC,
        calc_room <= last_idx_reg, "chosen room outside the active rooms")
    `LFRS_ASSERT_IMP(a_out_from_commit, $rose(out_valid_reg),
        $past(state_reg == S_DONE), "result appeared without a write-back")
    `LFRS_ASSERT_IMP(a_best_not_below, commit,
        (new_count_reg <= best_count_reg) || take_best, "busiest room missed a higher count")

endmodule

FILE: tb/lfrs_booking_checker.sv
// Booking checker for the lowest-free-room scheduler: predicts every booking and compares results.
module lfrs_booking_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [lfrs_pkg::CFG_W-1:0]      cfg_write_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [lfrs_pkg::TIME_W-1:0]     start_time,
    input  logic [lfrs_pkg::TIME_W-1:0]     end_time,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [lfrs_pkg::ROOM_OUT_W-1:0] room,
    input  logic [lfrs_pkg::TIME_W-1:0]     actual_start,
    input  logic [lfrs_pkg::TIME_W-1:0]     actual_end,
    input  logic                            was_delayed,
    input  logic [lfrs_pkg::ROOM_OUT_W-1:0] busiest_room,
    input  logic [lfrs_pkg::COUNT_W-1:0]    busiest_count,
    output int                              mismatches,
    output int                              awaiting
);
    import lfrs_pkg::*;

    localparam int ROOMS       = DEF_MAX_ROOMS;
    localparam int PRINT_LIMIT = 100;

    typedef logic [TIME_W-1:0] stamp_t;
    localparam stamp_t LATEST = '1;

    typedef struct packed {
        logic [ROOM_OUT_W-1:0] room;
        stamp_t                from_t;
        stamp_t                until_t;
        logic                  delayed;
        logic [ROOM_OUT_W-1:0] lead_room;
        logic [COUNT_W-1:0]    lead_uses;
    } booking_t;

    // Shadow copy of the scheduler's state.
    stamp_t                room_free_at [ROOMS];
    logic [COUNT_W-1:0]    room_uses    [ROOMS];
    logic [ROOM_OUT_W-1:0] lead_room;
    logic [COUNT_W-1:0]    lead_uses;
    logic [CFG_W-1:0]      rooms_cfg;

    booking_t bookings_due [$];
    booking_t want;
    int       results_seen;

    function automatic booking_t book_room(input stamp_t req_start, input stamp_t req_end);
        int       lanes;
        int       r;
        int       pick;
        int       soonest;
        bit       hit;
        stamp_t   span;
        stamp_t   from_t;
        stamp_t   until_t;
        booking_t res;
        lanes = int'(rooms_cfg);
        if (lanes == 0)
            lanes = 1;
        if (lanes > ROOMS)
            lanes = ROOMS;
        span    = (req_end > req_start) ? req_end - req_start : '0;
        hit     = 1'b0;
        pick    = 0;
        soonest = 0;
        for (r = 0; r < lanes; r++)
        begin
            if (!hit && room_free_at[r] <= req_start)
            begin
                pick = r;
                hit  = 1'b1;
            end
            if (room_free_at[r] < room_free_at[soonest])
                soonest = r;
        end
        if (hit)
            from_t = req_start;
        else
        begin
            pick   = soonest;
            from_t = room_free_at[soonest];
        end
        until_t = (span > LATEST - from_t) ? LATEST : from_t + span;
        room_free_at[pick] = until_t;
        if (room_uses[pick] != COUNT_MAX)
            room_uses[pick] = room_uses[pick] + 1'b1;
        if (room_uses[pick] > lead_uses ||
            (room_uses[pick] == lead_uses && pick < lead_room))
        begin
            lead_room = pick[ROOM_OUT_W-1:0];
            lead_uses = room_uses[pick];
        end
        res.room      = pick[ROOM_OUT_W-1:0];
        res.from_t    = from_t;
        res.until_t   = until_t;
        res.delayed   = !hit;
        res.lead_room = lead_room;
        res.lead_uses = lead_uses;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_v);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h at %0t",
                     results_seen, what, got, exp_v, $realtime);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROOMS; r++)
            begin
                room_free_at[r] = '0;
                room_uses[r]    = '0;
            end
            lead_room    = '0;
            lead_uses    = '0;
            rooms_cfg    = CFG_RESET;
            bookings_due.delete();
            mismatches   = 0;
            awaiting     = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_write_en)
                rooms_cfg = cfg_write_data;
            if (in_valid && in_ready)
                bookings_due.push_back(book_room(start_time, end_time));
            if (out_valid && out_ready)
            begin
                if (bookings_due.size() == 0)
                    report_mismatch("result with no booking waiting", 64'(room), 64'(0));
                else
                begin
                    want = bookings_due.pop_front();
                    if (room !== want.room)
                        report_mismatch("room", 64'(room), 64'(want.room));
                    if (actual_start !== want.from_t)
                        report_mismatch("actual_start", 64'(actual_start), 64'(want.from_t));
                    if (actual_end !== want.until_t)
                        report_mismatch("actual_end", 64'(actual_end), 64'(want.until_t));
                    if (was_delayed !== want.delayed)
                        report_mismatch("was_delayed", 64'(was_delayed), 64'(want.delayed));
                    if (busiest_room !== want.lead_room)
                        report_mismatch("busiest_room", 64'(busiest_room),
                                        64'(want.lead_room));
                    if (busiest_count !== want.lead_uses)
                        report_mismatch("busiest_count", 64'(busiest_count),
                                        64'(want.lead_uses));
                end
                results_seen++;
            end
            awaiting = bookings_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Top of the lowest-free-room scheduler testbench: clock, reset, stimulus and verdict.
module tb;
    import lfrs_pkg::*;

    // A run is stuck when no transfer happens on either channel for this many
    // cycles. The longest legal quiet stretch is the receiver's long hold-off.
    localparam int STUCK_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = DEF_MAX_ROOMS + 16;
    localparam int RANDOM_PHASES = 32;
    // Every random phase owns its own slice of the time axis, so rooms used by
    // one phase are mostly free again at the start of the next (a wild end
    // time can still hold a room longer), and the slices together sweep the
    // whole 40-bit range.
    localparam logic [63:0] PHASE_SPAN  = 64'd1 << 35;
    localparam logic [63:0] OFFSET_MASK = (64'd1 << 34) - 64'd1;

    typedef logic [TIME_W-1:0] stamp_t;
    localparam stamp_t LATEST = '1;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_W-1:0]      cfg_write_data;
    logic                  in_valid;
    logic                  in_ready;
    stamp_t                start_time;
    stamp_t                end_time;
    logic                  out_valid;
    logic                  out_ready;
    logic [ROOM_OUT_W-1:0] room;
    stamp_t                actual_start;
    stamp_t                actual_end;
    logic                  was_delayed;
    logic [ROOM_OUT_W-1:0] busiest_room;
    logic [COUNT_W-1:0]    busiest_count;

    int mismatches;
    int awaiting;
    int stuck_cycles;
    int holds_asked;
    int holds_taken;

    lowest_free_room_scheduler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_time     (start_time),
        .end_time       (end_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .room           (room),
        .actual_start   (actual_start),
        .actual_end     (actual_end),
        .was_delayed    (was_delayed),
        .busiest_room   (busiest_room),
        .busiest_count  (busiest_count)
    );

    lfrs_booking_checker u_booking_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_time     (start_time),
        .end_time       (end_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .room           (room),
        .actual_start   (actual_start),
        .actual_end     (actual_end),
        .was_delayed    (was_delayed),
        .busiest_room   (busiest_room),
        .busiest_count  (busiest_count),
        .mismatches     (mismatches),
        .awaiting       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: counts cycles without any transfer once reset is released.
    initial stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver. It picks a stall mode for a random stretch of cycles: always
    // ready, a coin toss, mostly stalled, or a rotating random bit pattern.
    // When the stimulus asks for it, it holds off for a long stretch so that
    // the output register and the request in flight back up into the input.
    initial
    begin
        rx_mode_t    mode;
        int          tick;
        logic [15:0] pattern;
        mode        = RX_STEADY;
        tick        = 0;
        pattern     = '1;
        holds_taken = 0;
        out_ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_taken < holds_asked)
            begin
                holds_taken++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (tick == 0)
                begin
                    mode    = rx_mode_t'($urandom_range(0, 3));
                    tick    = $urandom_range(16, 96);
                    pattern = 16'($urandom);
                end
                case (mode)
                    RX_STEADY:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                    RX_PATTERN:
                    begin
                        out_ready <= pattern[0];
                        pattern = {pattern[0], pattern[15:1]};
                    end
                    default:    out_ready <= 1'b1;
                endcase
                tick--;
            end
        end
    end

    // Offers one booking request and returns at the falling edge after its
    // transfer. Valid is left high, so a caller that sends again at once keeps
    // a continuous burst; a caller that wants a gap lowers it itself.
    task automatic send_booking(input stamp_t s, input stamp_t e);
        in_valid   <= 1'b1;
        start_time <= s;
        end_time   <= e;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Stops offering and waits until every booking sent has come back. Every
    // request produces exactly one result, so the block is idle afterwards.
    task automatic drain_bookings();
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
    endtask

    // Writes the room count register; only called while the block is idle.
    task automatic write_rooms(input logic [CFG_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    function automatic stamp_t clamp_stamp(input logic [63:0] v);
        return (v > 64'(LATEST)) ? LATEST : v[TIME_W-1:0];
    endfunction

    initial
    begin
        int          phase;
        int          n;
        int          items;
        int          setting;
        int          lanes;
        int          kind;
        int          burst_left;
        int          gap;
        int unsigned step_hi;
        int unsigned dur_hi;
        logic [63:0] cursor;
        logic [63:0] s64;
        logic [63:0] e64;
        logic [63:0] back;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        start_time     = '0;
        end_time       = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        holds_asked    = 0;
        burst_left     = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. The first booking runs at the reset room count
        // and uses the earliest possible start.
        send_booking(40'd0, 40'd10);

        // Two rooms: a start equal to a release time counts as free, a zero
        // and a negative duration, then a run of delayed bookings where the
        // last one arrives with a start earlier than the one before it.
        drain_bookings();
        write_rooms(7'd2);
        send_booking(40'd10, 40'd20);
        send_booking(40'd12, 40'd12);
        send_booking(40'd13, 40'd5);
        send_booking(40'd15, 40'd40);
        send_booking(40'd16, 40'd26);
        send_booking(40'd17, 40'd18);
        send_booking(40'd3, 40'd9);

        // One room, then a count of zero, which the block treats as one room.
        drain_bookings();
        write_rooms(7'd1);
        send_booking(40'd50, 40'd60);
        send_booking(40'd55, 40'd56);
        drain_bookings();
        write_rooms(7'd0);
        send_booking(40'd70, 40'd80);
        send_booking(40'd75, 40'd75);

        // The largest register value, clamped to the full set of rooms.
        drain_bookings();
        write_rooms(7'd127);
        send_booking(40'd100, 40'd110);
        send_booking(40'd105, 40'd106);

        // Random phases. Each one sets a room count, then sends mostly
        // well-formed requests with rising starts, mixed with zero or
        // negative durations, starts that go backwards and wild end times.
        // The ratio of duration to start spacing decides how often every
        // room is busy and a booking has to be delayed.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 1)
                setting = DEF_MAX_ROOMS;
            else if (phase == 2)
                setting = 127;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: setting = $urandom_range(1, 8);
                    6, 7:             setting = $urandom_range(9, 24);
                    8:                setting = 0;
                    default:          setting = $urandom_range(25, 127);
                endcase
            end
            lanes = (setting == 0) ? 1 : (setting > DEF_MAX_ROOMS) ? DEF_MAX_ROOMS : setting;

            // The sender waits here until every result of the last phase
            // is back before the register changes.
            drain_bookings();
            write_rooms(setting[CFG_W-1:0]);

            // Large room counts make every request slow, so those phases
            // stay short.
            items   = (lanes > 24) ? $urandom_range(4, 10) : $urandom_range(18, 50);
            step_hi = 32'd1 << $urandom_range(0, 22);
            dur_hi  = step_hi * $urandom_range(1, 2 * lanes + 2);
            cursor  = 64'(phase) * PHASE_SPAN + ({$urandom, $urandom} & OFFSET_MASK);

            // Twice in the run the receiver holds off while this phase keeps
            // offering, so the block fills up and stalls its input.
            if (phase == 6 || phase == 21)
                holds_asked++;

            for (n = 0; n < items; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                burst_left--;

                kind = $urandom_range(0, 99);
                if (kind < 85)
                begin
                    cursor = cursor + 64'($urandom_range(1, step_hi));
                    s64    = cursor;
                    e64    = s64 + 64'($urandom_range(1, dur_hi));
                end
                else if (kind < 91)
                begin
                    // End at or before the start: the room is held only
                    // until the actual start.
                    cursor = cursor + 64'($urandom_range(1, step_hi));
                    s64    = cursor;
                    back   = 64'($urandom_range(0, dur_hi));
                    e64    = (back > s64) ? 64'd0 : s64 - back;
                end
                else if (kind < 98)
                begin
                    // Start earlier than the previous request's start.
                    back = 64'($urandom_range(0, step_hi * 4));
                    s64  = (back > cursor) ? 64'd0 : cursor - back;
                    e64  = s64 + 64'($urandom_range(1, dur_hi));
                end
                else
                begin
                    cursor = cursor + 64'd1;
                    s64    = cursor;
                    e64    = {$urandom, $urandom} & 64'(LATEST);
                end
                send_booking(clamp_stamp(s64), clamp_stamp(e64));
            end
        end

        // Directed cases at the top of the time range run last, since a room
        // that reaches the largest time value never frees again. With one
        // room: a booking close to the top, a delayed booking whose end would
        // pass the largest time and saturates, starts at the largest time
        // with end equal to and below the start, and finally starts of zero
        // that must wait for the saturated room.
        drain_bookings();
        write_rooms(7'd1);
        send_booking(LATEST - 40'd100, LATEST - 40'd90);
        send_booking(LATEST - 40'd95, LATEST);
        send_booking(LATEST, LATEST);
        send_booking(LATEST, 40'd0);
        send_booking(40'd0, LATEST);
        send_booking(40'd0, 40'd0);

        drain_bookings();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
